// File: hdl/srec_stream_loader_unit_assert.svh
// Assertion macros shared by the loader RTL.
`ifndef SREC_STREAM_LOADER_UNIT_ASSERT_SVH
`define SREC_STREAM_LOADER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SREC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SREC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/srec_pkg.sv
package srec_pkg;

  localparam int CHAR_W         = 8;
  localparam int ADDR_W         = 32;
  localparam int BYTE_W         = 8;
  localparam int NIB_W          = 4;
  localparam int LINE_END_CHARS = 1;
  // 2*LL + line end, LL up to 255
  localparam int CHARS_W        = $clog2(2 * 255 + LINE_END_CHARS + 1);
  localparam int ADDR_NIBS      = ADDR_W / NIB_W;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_THREE = 8'h33;
  localparam logic [CHAR_W-1:0] CHAR_SEVEN = 8'h37;
  // 'A' - 10
  localparam logic [CHAR_W-1:0] CHAR_HEX_BASE = 8'h37;
  localparam logic [CHAR_W-1:0] CHAR_DEC_END  = 8'h3A;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

endpackage

// File: hdl/srec_char_if.sv
interface srec_char_if;
  logic                           valid;
  logic                           ready;
  logic [srec_pkg::CHAR_W-1:0]    character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

// File: hdl/srec_res_if.sv
interface srec_res_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [srec_pkg::ADDR_W-1:0]    address;
  logic [srec_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, output kind, output address, output data_byte, input ready);
  modport sink   (input valid, input kind, input address, input data_byte, output ready);
endinterface

// File: hdl/srec_stream_loader_unit.sv
// S-record loader: one character transaction per cycle, except while the output stalls.
// A result is registered: it is valid on the cycle after its character is accepted.
// Throughput: 1 character per cycle; the input stalls only while a result sits
// in the output register and is not taken that cycle.
// Reset (rst, synchronous): parser back to expect-lead, output empty, entry flag clear.
`include "srec_stream_loader_unit_assert.svh"

module srec_stream_loader_unit (
  input  logic          clk,
  input  logic          rst,
  srec_char_if.sink     stream,
  srec_res_if.source    result
);

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_COUNT = 3'd2;
  localparam logic [2:0] PH_ADDR  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_SKIP  = 3'd5;

  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_S3    = 2'd1;
  localparam logic [1:0] CLS_S7    = 2'd2;

  localparam int CW = srec_pkg::CHARS_W;
  localparam logic [CW-1:0] TAIL_CHARS = CW'(2 + srec_pkg::LINE_END_CHARS);
  localparam logic [srec_pkg::BYTE_W-1:0] ADDR_DONE = srec_pkg::BYTE_W'(srec_pkg::ADDR_NIBS);

  function automatic logic [srec_pkg::NIB_W-1:0] hex_nibble(
    input logic [srec_pkg::CHAR_W-1:0] c
  );
    logic [srec_pkg::CHAR_W-1:0] d;
    begin
      if (c < srec_pkg::CHAR_DEC_END) d = c - srec_pkg::CHAR_ZERO;
      else d = c - srec_pkg::CHAR_HEX_BASE;
      return d[srec_pkg::NIB_W-1:0];
    end
  endfunction

  logic [2:0]                     phase, phase_next;
  logic [1:0]                     record_class, record_class_next;
  logic [CW-1:0]                  chars_left, chars_left_next;
  logic [srec_pkg::NIB_W-1:0]     high_nibble, high_nibble_next;
  logic                           nibble_parity, nibble_parity_next;
  logic [srec_pkg::ADDR_W-1:0]    addr_acc, addr_acc_next;
  logic [srec_pkg::BYTE_W-1:0]    byte_offset, byte_offset_next;
  logic                           finished, finished_next;

  logic                           out_valid;
  logic                           out_kind;
  logic [srec_pkg::ADDR_W-1:0]    out_address;
  logic [srec_pkg::BYTE_W-1:0]    out_data;

  logic                           res_valid;
  logic                           res_kind;
  logic [srec_pkg::ADDR_W-1:0]    res_address;
  logic [srec_pkg::BYTE_W-1:0]    res_data;

  logic                           in_acc;
  logic [srec_pkg::NIB_W-1:0]     nib;
  logic [CW-1:0]                  consumed;
  logic [CW-1:0]                  count_chars;

  assign stream.ready = !out_valid || result.ready;
  assign in_acc       = stream.valid && stream.ready;
  assign nib          = hex_nibble(stream.character);
  assign consumed     = (chars_left != '0) ? chars_left - CW'(1) : chars_left;
  assign count_chars  = CW'({high_nibble, nib}) * CW'(2) + CW'(srec_pkg::LINE_END_CHARS);

  always_comb begin
    phase_next         = phase;
    record_class_next  = record_class;
    chars_left_next    = chars_left;
    high_nibble_next   = high_nibble;
    nibble_parity_next = nibble_parity;
    addr_acc_next      = addr_acc;
    byte_offset_next   = byte_offset;
    finished_next      = finished;
    res_valid          = 1'b0;
    res_kind           = srec_pkg::KIND_WRITE;
    res_address        = addr_acc + srec_pkg::ADDR_W'(byte_offset);
    res_data           = {high_nibble, nib};

    if (!finished) begin
      unique case (phase)
        PH_LEAD: begin
          phase_next = PH_TYPE;
        end
        PH_TYPE: begin
          if (stream.character == srec_pkg::CHAR_THREE) record_class_next = CLS_S3;
          else if (stream.character == srec_pkg::CHAR_SEVEN) record_class_next = CLS_S7;
          else record_class_next = CLS_OTHER;
          nibble_parity_next = 1'b0;
          phase_next = PH_COUNT;
        end
        PH_COUNT: begin
          if (!nibble_parity) begin
            high_nibble_next   = nib;
            nibble_parity_next = 1'b1;
          end else begin
            nibble_parity_next = 1'b0;
            chars_left_next    = count_chars;
            addr_acc_next      = '0;
            byte_offset_next   = '0;
            if (record_class == CLS_S7) phase_next = PH_ADDR;
            else if (count_chars == '0) phase_next = PH_LEAD;
            else if (record_class == CLS_S3) phase_next = PH_ADDR;
            else phase_next = PH_SKIP;
          end
        end
        PH_ADDR: begin
          addr_acc_next    = {addr_acc[srec_pkg::ADDR_W-srec_pkg::NIB_W-1:0], nib};
          byte_offset_next = byte_offset + 1'b1;
          if (record_class == CLS_S7) begin
            // entry record does not track its count
            if (byte_offset_next == ADDR_DONE) begin
              res_valid     = 1'b1;
              res_kind      = srec_pkg::KIND_ENTRY;
              res_address   = addr_acc_next;
              res_data      = '0;
              finished_next = 1'b1;
            end
          end else begin
            if (byte_offset_next == ADDR_DONE) begin
              byte_offset_next   = '0;
              nibble_parity_next = 1'b0;
              phase_next         = PH_DATA;
            end
            chars_left_next = consumed;
            if (consumed == '0) phase_next = PH_LEAD;
          end
        end
        PH_DATA: begin
          if (chars_left > TAIL_CHARS) begin
            if (!nibble_parity) begin
              high_nibble_next   = nib;
              nibble_parity_next = 1'b1;
            end else begin
              res_valid          = 1'b1;
              byte_offset_next   = byte_offset + 1'b1;
              nibble_parity_next = 1'b0;
            end
          end
          chars_left_next = consumed;
          if (consumed == '0) phase_next = PH_LEAD;
        end
        default: begin
          chars_left_next = consumed;
          if (consumed == '0) phase_next = PH_LEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      record_class  <= CLS_OTHER;
      chars_left    <= '0;
      high_nibble   <= '0;
      nibble_parity <= 1'b0;
      addr_acc      <= '0;
      byte_offset   <= '0;
      finished      <= 1'b0;
    end else if (in_acc) begin
      phase         <= phase_next;
      record_class  <= record_class_next;
      chars_left    <= chars_left_next;
      high_nibble   <= high_nibble_next;
      nibble_parity <= nibble_parity_next;
      addr_acc      <= addr_acc_next;
      byte_offset   <= byte_offset_next;
      finished      <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_kind    <= res_kind;
      out_address <= res_address;
      out_data    <= res_data;
    end
  end

  assign result.valid     = out_valid;
  assign result.kind      = out_kind;
  assign result.address   = out_address;
  assign result.data_byte = out_data;

  `SREC_ASSERT_NEXT(a_no_result_after_entry, finished && !out_valid, !out_valid, "result after entry point")
  `SREC_ASSERT_NOW(a_entry_data_zero, out_valid && out_kind == srec_pkg::KIND_ENTRY, out_data == '0, "entry result with nonzero data")
  `SREC_ASSERT_NEXT(a_entry_sets_finished, in_acc && res_valid && res_kind == srec_pkg::KIND_ENTRY, finished && out_valid, "entry result did not stop parser")
  `SREC_ASSERT_NOW(a_data_only_s3, phase == PH_DATA, record_class == CLS_S3, "data phase outside S3 record")
  `SREC_ASSERT_NOW(a_finished_rise_entry, $rose(finished), out_valid && out_kind == srec_pkg::KIND_ENTRY, "finished without entry result")

endmodule
